// File: sv/joint_trajectory_interpolator_unit_macros.svh
// assertion macros for the interpolator files, included by jti_blend
`ifndef JOINT_TRAJECTORY_INTERPOLATOR_UNIT_MACROS_SVH
`define JOINT_TRAJECTORY_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define JTI_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("interpolator assertion failed");

// next-cycle implication, quiet during reset
`define JTI_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("interpolator assertion failed");

`endif

// File: sv/jti_pkg.sv
package jti_pkg;

   // input beat
   typedef struct packed {
      logic [23:0]        elapsed_ticks;
      logic signed [31:0] start_angle;
      logic signed [31:0] goal_angle;
      logic signed [31:0] current_angle;
   } jti_req_type;

   // result beat
   typedef struct packed {
      logic signed [31:0] reference_angle;
      logic               path_complete;
   } jti_rsp_type;

   // configuration registers
   typedef struct packed {
      logic [2:0]  interp_mode;
      logic [31:0] step_rate;
      logic [26:0] max_step;
   } jti_cfg_type;

   // profile stage to blend stage
   typedef struct packed {
      logic               valid;
      logic               sel_goal;
      logic               done;
      logic               neg;
      logic [32:0]        mag;
      logic [31:0]        s;
      logic signed [31:0] start_angle;
      logic signed [31:0] goal_angle;
      logic signed [31:0] current_angle;
   } jti_blend_type;

   // register indexes
   localparam logic [1:0] CSR_INTERP_MODE = 2'd0;
   localparam logic [1:0] CSR_STEP_RATE   = 2'd1;
   localparam logic [1:0] CSR_MAX_STEP    = 2'd2;

   // profile codes
   localparam logic [2:0] MODE_SINE    = 3'd0;
   localparam logic [2:0] MODE_LINEAR  = 3'd1;
   localparam logic [2:0] MODE_CUBIC   = 3'd2;
   localparam logic [2:0] MODE_QUINTIC = 3'd3;
   localparam logic [2:0] MODE_STEP    = 3'd4;

   // reset values
   localparam logic [2:0]  RST_INTERP_MODE = MODE_LINEAR;
   localparam logic [31:0] RST_STEP_RATE   = 32'd42949673;
   localparam logic [26:0] RST_MAX_STEP    = 27'd9370497;

   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518853;
   localparam logic [63:0] INV_PI_Q32 = 64'd1367130551;
   localparam logic [34:0] ONE_Q31    = 35'h080000000;

   // cycloid table entry k: sin(2*pi*k/N)/pi in Q.31, evaluated at elaboration
   function automatic logic signed [31:0] jti_sine_entry(input int unsigned k,
                                                         input int unsigned bits);
      logic [63:0]        m;
      logic [63:0]        p;
      logic [63:0]        q;
      logic [63:0]        r;
      logic [63:0]        rr;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        tx;
      logic [63:0]        g;
      logic signed [63:0] sum;
      int                 i;
      m  = 64'd1 << (bits - 2);
      p  = 64'(k) & ((64'd1 << bits) - 64'd1);
      q  = p >> (bits - 2);
      r  = p & (m - 64'd1);
      rr = q[0] ? m - r : r;
      x  = (TWO_PI_Q30 * rr) >> bits;
      x2 = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (i = 1; i <= 7; i++) begin
         tx = (term * x2) >> 30;
         case (i)
            1: term = tx / 64'd6;
            2: term = tx / 64'd20;
            3: term = tx / 64'd42;
            4: term = tx / 64'd72;
            5: term = tx / 64'd110;
            6: term = tx / 64'd156;
            default: term = tx / 64'd210;
         endcase
         if (i % 2 == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 64'sd0;
      g = (64'(sum) * INV_PI_Q32) >> 31;
      return (q >= 64'd2) ? -$signed(g[31:0]) : $signed(g[31:0]);
   endfunction

endpackage

// File: sv/jti_sine_rom.sv
module jti_sine_rom #(
   parameter int TAB_BITS = 10
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [TAB_BITS-1:0]   addr,
   output logic signed [31:0]    rd_lo,
   output logic signed [31:0]    rd_hi
);
   import jti_pkg::*;

   localparam int TAB_N = 1 << TAB_BITS;

   logic signed [31:0] rom [TAB_N+1];
   logic [TAB_BITS:0]  addr_lo;
   logic [TAB_BITS:0]  addr_hi;
   logic signed [31:0] rd_lo_ff;
   logic signed [31:0] rd_hi_ff;

   // constant entries
   for (genvar k = 0; k <= TAB_N; k++) begin : g_ent
      localparam logic signed [31:0] ENTRY = jti_sine_entry(k, TAB_BITS);
      assign rom[k] = ENTRY;
   end

   assign addr_lo = {1'b0, addr};
   assign addr_hi = addr_lo + 1'b1;

   // registered reads of neighboring entries
   always_ff @(posedge clock) begin
      if (en) begin
         rd_lo_ff <= rom[addr_lo];
         rd_hi_ff <= rom[addr_hi];
      end
   end

   assign rd_lo = rd_lo_ff;
   assign rd_hi = rd_hi_ff;
endmodule

// File: sv/jti_profile.sv
module jti_profile #(
   parameter int TAB_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  jti_pkg::jti_cfg_type  cfg,
   input  logic                  in_valid,
   input  jti_pkg::jti_req_type  in_data,
   output jti_pkg::jti_blend_type out_stage
);
   import jti_pkg::*;

   localparam int FB = 31 - TAB_BITS;
   localparam int CW = 34 + FB;

   // stage 1: product of rate and ticks
   logic [24:0]   tick_inc;
   logic [56:0]   prod_in;
   logic          valid1_ff;
   logic [56:0]   prod1_ff;
   jti_req_type   req1_ff;

   assign tick_inc = {1'b0, in_data.elapsed_ticks} + 25'd1;
   assign prod_in  = {25'd0, cfg.step_rate} * {32'd0, tick_inc};

   always_ff @(posedge clock) begin
      if (reset) valid1_ff <= 1'b0;
      else if (en) valid1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff <= prod_in;
         req1_ff  <= in_data;
      end
   end

   // stage 2: time, its square, table lookup
   logic [30:0]        t_in;
   logic [61:0]        tsq_full;
   logic               valid2_ff;
   logic               done2_ff;
   logic [30:0]        t2_ff;
   logic [30:0]        tsq2_ff;
   jti_req_type        req2_ff;
   logic signed [31:0] tab_lo;
   logic signed [31:0] tab_hi;

   assign t_in     = prod1_ff[31:1];
   assign tsq_full = {31'd0, t_in} * {31'd0, t_in};

   jti_sine_rom #(.TAB_BITS(TAB_BITS)) u_rom (
      .clock (clock),
      .en    (en),
      .addr  (t_in[30:FB]),
      .rd_lo (tab_lo),
      .rd_hi (tab_hi)
   );

   always_ff @(posedge clock) begin
      if (reset) valid2_ff <= 1'b0;
      else if (en) valid2_ff <= valid1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         done2_ff <= |prod1_ff[56:32];
         t2_ff    <= t_in;
         tsq2_ff  <= tsq_full[61:31];
         req2_ff  <= req1_ff;
      end
   end

   // stage 3: cube, cubic profile, quintic polynomial, cycloid slope
   logic [61:0]           cube_full;
   logic [33:0]           cub_b;
   logic [64:0]           cub_full;
   logic [34:0]           poly_in;
   logic signed [32:0]    dtab;
   logic signed [CW-1:0]  cyc_in;
   logic                  valid3_ff;
   logic                  done3_ff;
   logic [30:0]           t3_ff;
   logic [30:0]           cube3_ff;
   logic [31:0]           cub3_ff;
   logic [34:0]           poly3_ff;
   logic signed [31:0]    tab3_ff;
   logic signed [CW-1:0]  cyc3_ff;
   jti_req_type           req3_ff;

   assign cube_full = {31'd0, tsq2_ff} * {31'd0, t2_ff};
   assign cub_b     = 34'h180000000 - {2'b00, t2_ff, 1'b0};
   assign cub_full  = {34'd0, tsq2_ff} * {31'd0, cub_b};
   assign poly_in   = 35'h500000000 + 35'(tsq2_ff) * 35'd6 - 35'(t2_ff) * 35'd15;
   assign dtab      = 33'(tab_hi) - 33'(tab_lo);
   assign cyc_in    = CW'(dtab) * CW'($signed({1'b0, t2_ff[FB-1:0]}));

   always_ff @(posedge clock) begin
      if (reset) valid3_ff <= 1'b0;
      else if (en) valid3_ff <= valid2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         done3_ff <= done2_ff;
         t3_ff    <= t2_ff;
         cube3_ff <= cube_full[61:31];
         cub3_ff  <= cub_full[62:31];
         poly3_ff <= poly_in;
         tab3_ff  <= tab_lo;
         cyc3_ff  <= cyc_in;
         req3_ff  <= req2_ff;
      end
   end

   // stage 4: quintic product, cycloid finish, profile select
   logic [65:0]         quin_full;
   logic [34:0]         quin;
   logic signed [34:0]  cyc_g;
   logic signed [35:0]  cyc_s;
   logic [34:0]         cyc_c;
   logic [34:0]         s_sel;
   logic [31:0]         s_in;
   logic signed [32:0]  diff;
   jti_blend_type       stage_ff;

   assign quin_full = {35'd0, cube3_ff} * {31'd0, poly3_ff};
   assign quin      = quin_full[65:31];
   assign cyc_g     = 35'(tab3_ff) + 35'(cyc3_ff >>> FB);
   assign cyc_s     = 36'($signed({1'b0, t3_ff})) - 36'(cyc_g);

   always_comb begin
      if (cyc_s < 0) cyc_c = 35'd0;
      else if (cyc_s > 36'(ONE_Q31)) cyc_c = ONE_Q31;
      else cyc_c = cyc_s[34:0];
   end

   always_comb begin
      case (cfg.interp_mode)
         MODE_SINE:    s_sel = cyc_c;
         MODE_LINEAR:  s_sel = 35'(t3_ff);
         MODE_CUBIC:   s_sel = 35'(cub3_ff);
         MODE_QUINTIC: s_sel = quin;
         default:      s_sel = 35'd0;
      endcase
   end

   assign s_in = (s_sel > ONE_Q31) ? ONE_Q31[31:0] : s_sel[31:0];
   assign diff = 33'(req3_ff.goal_angle) - 33'(req3_ff.start_angle);

   always_ff @(posedge clock) begin
      if (reset) stage_ff.valid <= 1'b0;
      else if (en) stage_ff.valid <= valid3_ff;
      if (en) begin
         stage_ff.sel_goal      <= done3_ff || (cfg.interp_mode == MODE_STEP);
         stage_ff.done          <= done3_ff;
         stage_ff.neg           <= diff[32];
         stage_ff.mag           <= diff[32] ? 33'(-diff) : 33'(diff);
         stage_ff.s             <= s_in;
         stage_ff.start_angle   <= req3_ff.start_angle;
         stage_ff.goal_angle    <= req3_ff.goal_angle;
         stage_ff.current_angle <= req3_ff.current_angle;
      end
   end

   assign out_stage = stage_ff;
endmodule

// File: sv/jti_blend.sv
`include "joint_trajectory_interpolator_unit_macros.svh"
module jti_blend (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [26:0]            max_step,
   input  jti_pkg::jti_blend_type in_stage,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output jti_pkg::jti_rsp_type   rsp_data
);
   import jti_pkg::*;

   typedef struct packed {
      logic               valid;
      logic               sel_goal;
      logic               done;
      logic               neg;
      logic [32:0]        off;
      logic signed [31:0] start_angle;
      logic signed [31:0] goal_angle;
      logic signed [31:0] current_angle;
   } jti_off_type;

   // stage 5: offset magnitude
   logic [64:0] off_full;
   jti_off_type r5_ff;

   assign off_full = {32'd0, in_stage.mag} * {33'd0, in_stage.s};

   always_ff @(posedge clock) begin
      if (reset) r5_ff.valid <= 1'b0;
      else if (en) r5_ff.valid <= in_stage.valid;
      if (en) begin
         r5_ff.sel_goal      <= in_stage.sel_goal;
         r5_ff.done          <= in_stage.done;
         r5_ff.neg           <= in_stage.neg;
         r5_ff.off           <= off_full[63:31];
         r5_ff.start_angle   <= in_stage.start_angle;
         r5_ff.goal_angle    <= in_stage.goal_angle;
         r5_ff.current_angle <= in_stage.current_angle;
      end
   end

   // stage 6: apply offset, clamp around current angle, saturate
   logic signed [35:0] ref_raw;
   logic signed [35:0] cur_x;
   logic signed [35:0] lim_x;
   logic signed [35:0] dev;
   logic signed [35:0] ref_clamp;
   logic signed [31:0] ref_sat;
   logic               rsp_valid_ff;
   jti_rsp_type        rsp_data_ff;

   assign cur_x = 36'(r5_ff.current_angle);
   assign lim_x = $signed({9'd0, max_step});

   always_comb begin
      if (r5_ff.sel_goal) ref_raw = 36'(r5_ff.goal_angle);
      else if (r5_ff.neg) ref_raw = 36'(r5_ff.start_angle) - $signed({3'd0, r5_ff.off});
      else ref_raw = 36'(r5_ff.start_angle) + $signed({3'd0, r5_ff.off});
   end

   assign dev = ref_raw - cur_x;

   always_comb begin
      if (dev > lim_x) ref_clamp = cur_x + lim_x;
      else if (dev < -lim_x) ref_clamp = cur_x - lim_x;
      else ref_clamp = ref_raw;
   end

   always_comb begin
      if (ref_clamp > 36'sd2147483647) ref_sat = 32'sh7fffffff;
      else if (ref_clamp < -36'sd2147483648) ref_sat = 32'sh80000000;
      else ref_sat = ref_clamp[31:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= r5_ff.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.reference_angle <= ref_sat;
         rsp_data_ff.path_complete   <= r5_ff.done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `JTI_ASSERT_NEXT(a_stage_holds, r5_ff.valid && !en, r5_ff.valid && $stable(r5_ff))
   `JTI_ASSERT_IMPL(a_done_takes_goal, r5_ff.valid && r5_ff.done, r5_ff.sel_goal)
   `JTI_ASSERT_NEXT(a_drain_empty, rsp_valid_ff && !rsp_stall && !r5_ff.valid, !rsp_valid_ff)
endmodule

// File: sv/joint_trajectory_interpolator_unit.sv
// path: a beat accepted on req passes stages 1 to 6 in order and shows on rsp from the output register
// throughput: one beat per cycle through a six-stage pipeline that stalls as a whole
// the pipe advances whenever the output register is empty or being taken
// reset (synchronous, active high) clears all stage valid bits and loads
// interp_mode, step_rate and max_step with their defaults; csr writes are always ready
module joint_trajectory_interpolator_unit #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  jti_pkg::jti_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output jti_pkg::jti_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import jti_pkg::*;

   jti_cfg_type   cfg_ff;
   jti_blend_type stage;
   logic          pipe_en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interp_mode <= RST_INTERP_MODE;
         cfg_ff.step_rate   <= RST_STEP_RATE;
         cfg_ff.max_step    <= RST_MAX_STEP;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INTERP_MODE: cfg_ff.interp_mode <= csr_wdata[2:0];
            CSR_STEP_RATE:   cfg_ff.step_rate   <= csr_wdata;
            CSR_MAX_STEP:    cfg_ff.max_step    <= csr_wdata[26:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // global advance
   assign pipe_en   = !rsp_valid || !rsp_stall;
   assign req_stall = !pipe_en;

   jti_profile #(.TAB_BITS(SINE_TABLE_BITS)) u_profile (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_stage (stage)
   );

   jti_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .max_step  (cfg_ff.max_step),
      .in_stage  (stage),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import jti_pkg::*;

   localparam int                TAB_BITS  = 10;
   localparam int                TAB_SIZE  = 1 << TAB_BITS;
   localparam int                FRAC_BITS = 31 - TAB_BITS;
   localparam longint unsigned   UNIT_Q31  = 64'h8000_0000;
   localparam longint unsigned   TWO_PI_Q  = 64'd6746518853;
   localparam longint unsigned   INV_PI_Q  = 64'd1367130551;
   localparam logic [26:0]       STEP_TOP  = 27'd67108864;

   // one directed beat with the settings it runs under
   typedef struct {
      logic [2:0]  mode;
      logic [31:0] rate;
      logic [26:0] max_step;
      jti_req_type beat;
      bit          typed;
      jti_rsp_type result;
   } joint_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   jti_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   jti_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // shadow of the register file
   logic [2:0]  cur_mode = RST_INTERP_MODE;
   logic [31:0] cur_rate = RST_STEP_RATE;
   logic [26:0] cur_max  = RST_MAX_STEP;

   longint         cycloid_tab [0:TAB_SIZE];
   jti_rsp_type    pending_refs [$];
   joint_case_type directed_cases [$];
   int             error_count = 0;
   bit             calm = 1'b0;
   bit             hold_off_req = 1'b0;
   int             hold_left = 0;

   joint_trajectory_interpolator_unit #(.SINE_TABLE_BITS(TAB_BITS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // floor(a*b / 2^31)
   function automatic longint unsigned q31_mul(longint unsigned a, longint unsigned b);
      longint unsigned hi;
      longint unsigned lo;
      hi = a * (b >> 16);
      lo = (a * (b & 64'hFFFF)) >> 16;
      return (hi + lo) >> 15;
   endfunction

   // sin(2*pi*k/N)/pi in Q.31 from a quarter-wave Taylor series
   function automatic longint cycloid_entry(int k);
      int              quarter;
      int              pos;
      int              seg;
      int              off;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      longint unsigned g;
      quarter = TAB_SIZE / 4;
      pos = k & (TAB_SIZE - 1);
      seg = pos / quarter;
      off = pos % quarter;
      if (seg & 1) off = quarter - off;
      x = (TWO_PI_Q * longint'(off)) >> TAB_BITS;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n & 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      g = (longint'(acc) * INV_PI_Q) >> 31;
      return (seg >= 2) ? -longint'(g) : longint'(g);
   endfunction

   // expected reference angle for one joint beat
   function automatic jti_rsp_type predict_reference(jti_req_type d, logic [2:0] mode,
                                                    logic [31:0] rate, logic [26:0] lim_q);
      longint unsigned prod;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned s;
      longint unsigned mag;
      longint unsigned off;
      longint unsigned idx;
      longint          frac;
      longint          g;
      longint          sc;
      longint          diff;
      longint          ref_v;
      longint          start_v;
      longint          goal_v;
      longint          cur_v;
      longint          lim;
      bit              done;
      jti_rsp_type     r;
      start_v = longint'(d.start_angle);
      goal_v  = longint'(d.goal_angle);
      cur_v   = longint'(d.current_angle);
      lim     = longint'({37'd0, lim_q});
      prod = longint'({32'd0, rate}) * (longint'({40'd0, d.elapsed_ticks}) + 1);
      done = prod >= 64'h1_0000_0000;
      if (done || mode == MODE_STEP) begin
         ref_v = goal_v;
      end else begin
         t = prod >> 1;
         t2 = q31_mul(t, t);
         case (mode)
            MODE_SINE: begin
               idx = (t >> FRAC_BITS) & (TAB_SIZE - 1);
               frac = longint'(t & ((64'd1 << FRAC_BITS) - 1));
               g = cycloid_tab[idx]
                   + (((cycloid_tab[idx + 1] - cycloid_tab[idx]) * frac) >>> FRAC_BITS);
               sc = longint'(t) - g;
               if (sc < 0) sc = 0;
               if (sc > longint'(UNIT_Q31)) sc = longint'(UNIT_Q31);
               s = longint'(sc);
            end
            MODE_LINEAR:  s = t;
            MODE_CUBIC:   s = q31_mul(t2, 3 * UNIT_Q31 - 2 * t);
            MODE_QUINTIC: s = q31_mul(q31_mul(t2, t), 10 * UNIT_Q31 + 6 * t2 - 15 * t);
            default:      s = 0;
         endcase
         if (s > UNIT_Q31) s = UNIT_Q31;
         diff = goal_v - start_v;
         mag = (diff < 0) ? -diff : diff;
         off = (mag * s) >> 31;
         ref_v = (diff < 0) ? start_v - longint'(off) : start_v + longint'(off);
      end
      // stay within max_step of the measured angle, then saturate
      if (ref_v - cur_v > lim) ref_v = cur_v + lim;
      else if (ref_v - cur_v < -lim) ref_v = cur_v - lim;
      if (ref_v > 64'sd2147483647) ref_v = 64'sd2147483647;
      if (ref_v < -64'sd2147483648) ref_v = -64'sd2147483648;
      r.reference_angle = ref_v[31:0];
      r.path_complete = done;
      return r;
   endfunction

   // send one beat, idling now and then
   task automatic send_joint(jti_req_type d, bit typed, jti_rsp_type typed_rsp);
      while (!calm && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed) pending_refs.push_back(typed_rsp);
      else pending_refs.push_back(predict_reference(d, cur_mode, cur_rate, cur_max));
   endtask

   // wait for all results, then let the pipe drain
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_refs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_INTERP_MODE: cur_mode = val[2:0];
         CSR_STEP_RATE:   cur_rate = val;
         CSR_MAX_STEP:    cur_max  = val[26:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(logic [2:0] mode, logic [31:0] rate, logic [26:0] lim_q);
      if (mode != cur_mode || rate != cur_rate || lim_q != cur_max) begin
         settle_pipeline();
         write_csr(CSR_INTERP_MODE, {29'd0, mode});
         write_csr(CSR_STEP_RATE, rate);
         write_csr(CSR_MAX_STEP, {5'd0, lim_q});
      end
   endtask

   task automatic add_case(logic [2:0] mode, logic [31:0] rate, logic [26:0] lim_q,
                           logic [23:0] ticks, logic [31:0] st, logic [31:0] gl,
                           logic [31:0] cu, bit typed, logic [31:0] exp_ref, logic exp_done);
      joint_case_type c;
      c.mode = mode;
      c.rate = rate;
      c.max_step = lim_q;
      c.beat = '{elapsed_ticks: ticks, start_angle: st, goal_angle: gl, current_angle: cu};
      c.typed = typed;
      c.result = '{reference_angle: exp_ref, path_complete: exp_done};
      directed_cases.push_back(c);
   endtask

   // random beat: mostly paths still in motion, some with any tick count
   function automatic jti_req_type random_joint();
      jti_req_type     d;
      longint unsigned span;
      d.start_angle = $urandom;
      d.goal_angle  = ($urandom_range(0, 1)) ? $urandom
                      : d.start_angle + $signed($urandom_range(0, 2 ** 28) - 2 ** 27);
      d.current_angle = ($urandom_range(0, 2)) ? d.start_angle
                        + $signed($urandom_range(0, 2 ** 25) - 2 ** 24) : $urandom;
      if (cur_rate == 0 || $urandom_range(0, 99) < 25) begin
         d.elapsed_ticks = 24'($urandom);
      end else begin
         span = 64'hFFFF_FFFF / cur_rate;
         if (span > 64'h100_0000) span = 64'h100_0000;
         d.elapsed_ticks = 24'($urandom_range(0, int'(span - 1)));
      end
      return d;
   endfunction

   // result checking
   always @(posedge clock) begin
      jti_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_refs.size() == 0) begin
            $display("%0t: unexpected result ref=%0d done=%0b", $time,
                     rsp_data.reference_angle, rsp_data.path_complete);
            error_count++;
         end else begin
            want = pending_refs.pop_front();
            if (rsp_data.reference_angle !== want.reference_angle) begin
               $display("%0t: reference_angle expected %0d actual %0d", $time,
                        want.reference_angle, rsp_data.reference_angle);
               error_count++;
            end
            if (rsp_data.path_complete !== want.path_complete) begin
               $display("%0t: path_complete expected %0b actual %0b", $time,
                        want.path_complete, rsp_data.path_complete);
               error_count++;
            end
         end
      end
   end

   // result side back-pressure, with one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = 300;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 29);
         end
      end
   end

   initial begin
      #50_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [31:0] rate;
      logic [26:0] lim_q;
      int          pick;
      for (int k = 0; k <= TAB_SIZE; k++) cycloid_tab[k] = cycloid_entry(k);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed beats: reset settings, completion, step, clamps, each profile
      add_case(MODE_LINEAR, RST_STEP_RATE, RST_MAX_STEP, 24'd0, 0, 0, 0, 1, 0, 0);
      add_case(MODE_LINEAR, RST_STEP_RATE, RST_MAX_STEP, 24'd49, 32'hF000_0000,
               32'h0800_0000, 32'hF800_0000, 0, 0, 0);
      add_case(MODE_LINEAR, 32'hFFFF_FFFF, RST_MAX_STEP, 24'd1, 32'd5, 32'd1000, 32'd1000,
               1, 32'd1000, 1);
      add_case(MODE_LINEAR, 32'hFFFF_FFFF, STEP_TOP, 24'hFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
      add_case(MODE_LINEAR, 32'd0, RST_MAX_STEP, 24'hFF_FFFF, -32'sd5, 32'd7, -32'sd5,
               1, -32'sd5, 0);
      add_case(MODE_STEP, 32'd0, RST_MAX_STEP, 24'd0, 32'd0, 32'h8000_0000,
               32'h8000_0000, 1, 32'h8000_0000, 0);
      add_case(MODE_STEP, 32'd0, RST_MAX_STEP, 24'd3, 32'd0, 32'h7FFF_FFFF, 32'd0,
               1, 32'd9370497, 0);
      add_case(MODE_STEP, 32'd0, RST_MAX_STEP, 24'd3, 32'd0, 32'h8000_0000, 32'd0,
               1, -32'sd9370497, 0);
      add_case(MODE_STEP, 32'd0, 27'd0, 24'd3, 32'd0, 32'h7FFF_FFFF, 32'd77,
               1, 32'd77, 0);
      for (int m = 0; m < 4; m++) begin
         add_case(m[2:0], 32'd42949673, STEP_TOP, 24'd24, 32'h0000_0000, 32'h0400_0000,
                  32'h0200_0000, 0, 0, 0);
         add_case(m[2:0], 32'd42949673, STEP_TOP, 24'd98, 32'h0400_0000, 32'hFC00_0000,
                  32'hFC00_0000, 0, 0, 0);
         add_case(m[2:0], 32'h7FFF_FFFF, STEP_TOP, 24'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0000_0000, 0, 0, 0);
         add_case(m[2:0], 32'd1000, STEP_TOP, 24'd3_000_000, 32'h1234_5678, 32'hE000_0001,
                  32'h0000_0000, 0, 0, 0);
      end
      foreach (directed_cases[i]) begin
         apply_settings(directed_cases[i].mode, directed_cases[i].rate,
                        directed_cases[i].max_step);
         send_joint(directed_cases[i].beat, directed_cases[i].typed,
                    directed_cases[i].result);
      end

      // random phases, each under fresh settings
      for (int ph = 0; ph < 14; ph++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: rate = 32'd0;
            1: rate = 32'hFFFF_FFFF;
            2, 3: rate = $urandom;
            default: rate = $urandom_range(1, 20000);
         endcase
         pick = $urandom_range(0, 5);
         case (pick)
            0: lim_q = 27'd0;
            1: lim_q = STEP_TOP;
            2: lim_q = 27'($urandom_range(0, 2 ** 26));
            default: lim_q = STEP_TOP - 27'($urandom_range(0, 2 ** 16));
         endcase
         if (ph == 0) begin
            rate = 32'hFFFF_FFFF;
            lim_q = 27'd0;
         end
         settle_pipeline();
         write_csr(CSR_INTERP_MODE, (ph < 5) ? ph : $urandom_range(0, 4));
         write_csr(CSR_STEP_RATE, rate);
         write_csr(CSR_MAX_STEP, {5'd0, lim_q});
         calm = (ph == 3);
         if (ph == 6) hold_off_req = 1'b1;
         for (int n = 0; n < 130; n++) send_joint(random_joint(), 0, '0);
         calm = 1'b0;
      end

      settle_pipeline();
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/jti_pkg.sv
sv/jti_sine_rom.sv
sv/jti_profile.sv
sv/jti_blend.sv
sv/joint_trajectory_interpolator_unit.sv
bench/testbench.sv
